// ----- hdl/mkd_pkg.sv -----
// ----------------------------------------------------------------------------
// Morse keying decoder package
// Shared constants, register indexes, the Morse code table and its lookup.
// ----------------------------------------------------------------------------
package mkd_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned MaxSymbolsDef      = 6;
  localparam int unsigned TickCounterBitsDef = 16;

  // Configuration register width and reset values.
  localparam int unsigned CfgW          = 16;
  localparam logic [CfgW-1:0] DotMinRst  = 16'd50;
  localparam logic [CfgW-1:0] DashMinRst = 16'd150;
  localparam logic [CfgW-1:0] CharGapRst = 16'd1000;

  // Register indexes on the configuration port.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t RegDotMin  = 2'd0;
  localparam cfg_idx_t RegDashMin = 2'd1;
  localparam cfg_idx_t RegCharGap = 2'd2;

  // Output character width and ASCII bases.
  localparam int unsigned CharW       = 7;
  localparam int unsigned AsciiUpperA = 65;
  localparam int unsigned AsciiZero   = 48;

  // Table geometry: pattern length and pattern bits as seen by the lookup.
  localparam int unsigned TableSize   = 36;
  localparam int unsigned LetterCount = 26;
  localparam int unsigned LenW        = 4;
  localparam int unsigned PatW        = 8;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [PatW-1:0] bits;
  } pattern_t;

  // A-Z then 0-9; symbol k sits in bit k, a dash is 1.
  localparam pattern_t CodeTable [TableSize] = '{
    '{4'd2, 8'd2},  '{4'd4, 8'd1},  '{4'd4, 8'd5},  '{4'd3, 8'd1},
    '{4'd1, 8'd0},  '{4'd4, 8'd4},  '{4'd3, 8'd3},  '{4'd4, 8'd0},
    '{4'd2, 8'd0},  '{4'd4, 8'd14}, '{4'd3, 8'd5},  '{4'd4, 8'd2},
    '{4'd2, 8'd3},  '{4'd2, 8'd1},  '{4'd3, 8'd7},  '{4'd4, 8'd6},
    '{4'd4, 8'd11}, '{4'd3, 8'd2},  '{4'd3, 8'd0},  '{4'd1, 8'd1},
    '{4'd3, 8'd4},  '{4'd4, 8'd8},  '{4'd3, 8'd6},  '{4'd4, 8'd9},
    '{4'd4, 8'd13}, '{4'd4, 8'd3},
    '{4'd5, 8'd31}, '{4'd5, 8'd30}, '{4'd5, 8'd28}, '{4'd5, 8'd24},
    '{4'd5, 8'd16}, '{4'd5, 8'd0},  '{4'd5, 8'd1},  '{4'd5, 8'd3},
    '{4'd5, 8'd7},  '{4'd5, 8'd15}
  };

  // One decoded character heading for the output buffer.
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] char_code;
  } char_push_t;

  // Returns the ASCII code of a buffered pattern, or zero when none matches.
  // Table entries are unique, so at most one compare hits.
  function automatic logic [CharW-1:0] lookup_char(input logic [LenW-1:0] len,
                                                   input logic [PatW-1:0] bits);
    logic [CharW-1:0] res;
    res = '0;
    for (int i = 0; i < TableSize; i++) begin
      if (CodeTable[i].len == len && CodeTable[i].bits == bits) begin
        if (i < LetterCount) begin
          res = CharW'(AsciiUpperA + i);
        end else begin
          res = CharW'(AsciiZero + i - LetterCount);
        end
      end
    end
    return res;
  endfunction

endpackage

// ----- hdl/morse_keying_decoder.sv -----
// ----------------------------------------------------------------------------
// Morse keying decoder
// Times high pulses on a sampled keying line and emits decoded A-Z / 0-9.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one line_level_i sample per word, taken when in_valid_i is
//   high and in_stall_o is low. Each sample is one tick of pulse and gap time.
//   Output channel: decoded_char_o carries an ASCII letter or digit, taken
//   when out_valid_o is high and out_stall_i is low. A sample yields zero or
//   one character.
//   Output timing: with the output buffer empty, a character caused by a
//   sample is on the output right after the edge that accepted that sample.
//   Otherwise it waits behind the held words.
//   Throughput: one sample per cycle while in_stall_o is low; counters,
//   classification and the table lookup all settle in the cycle a sample is accepted.
//   Stalls: characters wait in a two-word output buffer. in_stall_o rises
//   only while both words are held, so a stalled receiver blocks the input
//   only after two characters are pending.
//   Reset: thresholds return to 50, 150 and 1000 ticks, the symbol buffer
//   and counters clear, and the output buffer empties.
//   Configuration writes take effect on the next accepted sample.
// ----------------------------------------------------------------------------
module morse_keying_decoder #(
  parameter int unsigned MaxSymbols      = mkd_pkg::MaxSymbolsDef,
  parameter int unsigned TickCounterBits = mkd_pkg::TickCounterBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  mkd_pkg::cfg_idx_t          cfg_idx_i,
  input  logic [mkd_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       line_level_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mkd_pkg::CharW-1:0]  decoded_char_o
);
  import mkd_pkg::*;

  localparam int unsigned CntW = $clog2(MaxSymbols + 1);
  localparam int unsigned CmpW = (TickCounterBits > CfgW) ? TickCounterBits : CfgW;

  logic [CfgW-1:0]            dot_min_q, dash_min_q, char_gap_q;
  logic                       prev_q, prev_d;
  logic [TickCounterBits-1:0] pulse_q, pulse_d;
  logic [TickCounterBits-1:0] gap_q, gap_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [MaxSymbols-1:0]      bits_q, bits_d;
  logic                       accept;
  logic                       is_dash, is_valid_pulse;
  logic [TickCounterBits-1:0] gap_inc;
  logic [CharW-1:0]           lookup;
  char_push_t                 push;

  assign accept = in_valid_i & ~in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_min_q  <= DotMinRst;
      dash_min_q <= DashMinRst;
      char_gap_q <= CharGapRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDotMin:  dot_min_q  <= cfg_wdata_i;
        RegDashMin: dash_min_q <= cfg_wdata_i;
        RegCharGap: char_gap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pulse classification against the thresholds.
  assign is_dash        = CmpW'(pulse_q) >= CmpW'(dash_min_q);
  assign is_valid_pulse = is_dash || (CmpW'(pulse_q) >= CmpW'(dot_min_q));
  assign gap_inc        = (gap_q == '1) ? gap_q : gap_q + 1'b1;

  // Per-sample state update and end-of-character decode.
  always_comb begin
    prev_d         = prev_q;
    pulse_d        = pulse_q;
    gap_d          = gap_q;
    count_d        = count_q;
    bits_d         = bits_q;
    push.valid     = 1'b0;
    push.char_code = '0;
    lookup         = '0;
    if (accept) begin
      if (line_level_i) begin
        pulse_d = (pulse_q == '1) ? pulse_q : pulse_q + 1'b1;
      end else if (prev_q) begin
        // Falling edge: a counted pulse restarts the gap, others do not.
        if (is_valid_pulse && count_q < CntW'(MaxSymbols)) begin
          for (int k = 0; k < MaxSymbols; k++) begin
            if (count_q == CntW'(k) && is_dash) begin
              bits_d[k] = 1'b1;
            end
          end
          count_d = count_q + CntW'(1);
          gap_d   = '0;
        end else begin
          gap_d = gap_inc;
        end
        pulse_d = '0;
      end else begin
        gap_d = gap_inc;
      end
      prev_d = line_level_i;

      // A full buffer or a long enough gap ends the character.
      if (count_d != '0 &&
          (count_d >= CntW'(MaxSymbols) || CmpW'(gap_d) >= CmpW'(char_gap_q))) begin
        lookup         = lookup_char(LenW'(count_d), PatW'(bits_d));
        push.valid     = (lookup != '0);
        push.char_code = lookup;
        count_d        = '0;
        bits_d         = '0;
      end
    end
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      pulse_q <= '0;
      gap_q   <= '0;
      count_q <= '0;
      bits_q  <= '0;
    end else begin
      prev_q  <= prev_d;
      pulse_q <= pulse_d;
      gap_q   <= gap_d;
      count_q <= count_d;
      bits_q  <= bits_d;
    end
  end

  // Output register with skid entry.
  mkd_out_buf u_out_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .decoded_char_o (decoded_char_o)
  );

endmodule

// ----- hdl/mkd_out_buf.sv -----
// ----------------------------------------------------------------------------
// Morse keying decoder output buffer
// Two-word output register with a skid entry; stalls the input when full.
// ----------------------------------------------------------------------------
module mkd_out_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mkd_pkg::char_push_t        push_i,
  output logic                       full_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mkd_pkg::CharW-1:0]  decoded_char_o
);
  import mkd_pkg::*;

  logic             head_vld_q, head_vld_d;
  logic             skid_vld_q, skid_vld_d;
  logic [CharW-1:0] head_q, head_d;
  logic [CharW-1:0] skid_q, skid_d;
  logic             pop;

  assign pop = head_vld_q & ~out_stall_i;

  // Next occupancy and contents; the head word always leaves first.
  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        head_d     = skid_q;
        head_vld_d = 1'b1;
        skid_d     = push_i.char_code;
        skid_vld_d = push_i.valid;
      end else begin
        head_d     = push_i.char_code;
        head_vld_d = push_i.valid;
      end
    end else if (push_i.valid) begin
      if (!head_vld_q) begin
        head_d     = push_i.char_code;
        head_vld_d = 1'b1;
      end else begin
        skid_d     = push_i.char_code;
        skid_vld_d = 1'b1;
      end
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Payload words.
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o         = skid_vld_q;
  assign out_valid_o    = head_vld_q;
  assign decoded_char_o = head_q;

endmodule
